@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the sorted list RTL.
// Depends on nothing; the including module supplies clock and reset names.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, switched off while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/slir_pkg.sv @@
// Package of the sorted list block: controller states, request and status codes,
// and the command struct from the controller to the datapath. Depends on nothing.
package slir_pkg;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic {
		REQ_INSERT = 1'b0,
		REQ_REMOVE = 1'b1
	} req_t;

	typedef enum logic {
		S_IDLE   = 1'b0,
		S_UPDATE = 1'b1
	} state_t;

	typedef struct packed {
		logic capture;
		logic commit;
	} cmd_t;

	localparam int OUT_W = 40;

endpackage

@@ hw/rtl/slir_ctrl.sv @@
// Controller of the sorted list block: request handshake, state machine and the
// output valid flag. Depends on slir_pkg and assert_macros.svh.
`include "assert_macros.svh"

module slir_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	output logic            m_tvalid,
	input  logic            m_tready,
	output slir_pkg::cmd_t  cmd
);

	slir_pkg::state_t state_q, state_d;
	logic             out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= slir_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		s_tready    = 1'b0;
		unique case (state_q)
			slir_pkg::S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = slir_pkg::S_UPDATE;
				end
			end
			slir_pkg::S_UPDATE: begin
				// The result may only be written once the output register is free.
				if (!out_valid_q || m_tready) begin
					cmd.commit = 1'b1;
					state_d    = slir_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = slir_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;

	`ASSERT_IMPLIES(a_commit_slot_free, clk, arst_n, cmd.commit, (!out_valid_q || m_tready), "commit overwrote a pending result")
	`ASSERT_NEXT(a_capture_to_update, clk, arst_n, cmd.capture, (state_q == slir_pkg::S_UPDATE), "capture not followed by update")
	`ASSERT_IMPLIES(a_valid_from_commit, clk, arst_n, $rose(m_tvalid), $past(cmd.commit), "result appeared without a commit")

endmodule

@@ hw/rtl/slir_dpath.sv @@
// Datapath of the sorted list block: the row of compare-and-shift cells, the
// entry count and the result register. Depends on slir_pkg.
module slir_dpath #(
	parameter int CAPACITY = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  slir_pkg::cmd_t              cmd,
	input  logic                        in_req_type,
	input  logic signed [31:0]          in_value,
	output logic [slir_pkg::OUT_W-1:0]  out_data
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic signed [31:0]   cell_q [CAPACITY];
	logic signed [31:0]   cell_d [CAPACITY];
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        count_n;
	logic                 req_q;
	logic signed [31:0]   value_q;
	logic [CAPACITY-1:0]  ge_c, eq_c, after_c;
	logic [CAPACITY-1:0]  ge_q, eq_q, after_q;
	logic                 full, found, ok;
	slir_pkg::status_t    status_c;
	logic signed [31:0]   smallest_c;
	logic [CW+4:0]        count_ext;
	logic [slir_pkg::OUT_W-1:0] out_q;

	// Each cell compares its own entry with the incoming value.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cmp
		logic valid;
		assign valid      = CW'(i) < count_q;
		assign ge_c[i]    = valid && (cell_q[i] >= in_value);
		assign eq_c[i]    = valid && (cell_q[i] == in_value);
		assign after_c[i] = ge_c[i] || !valid;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q   <= in_req_type;
			value_q <= in_value;
			ge_q    <= ge_c;
			eq_q    <= eq_c;
			after_q <= after_c;
		end
	end

	assign full  = count_q == CW'(CAPACITY);
	assign found = |eq_q;

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			cell_d[i] = cell_q[i];
		end
		if (req_q == slir_pkg::REQ_INSERT) begin
			if (after_q[0]) begin
				cell_d[0] = value_q;
			end
			for (int i = 1; i < CAPACITY; i++) begin
				if (after_q[i - 1]) begin
					cell_d[i] = cell_q[i - 1];
				end else if (after_q[i]) begin
					cell_d[i] = value_q;
				end
			end
		end else begin
			// The list is sorted, so the entries from the first equal one on are
			// exactly those not smaller than the value.
			for (int i = 0; i < CAPACITY - 1; i++) begin
				if (ge_q[i]) begin
					cell_d[i] = cell_q[i + 1];
				end
			end
		end
	end

	always_comb begin
		count_n = count_q;
		if (req_q == slir_pkg::REQ_INSERT) begin
			ok       = !full;
			status_c = full ? slir_pkg::ST_FULL : slir_pkg::ST_OK;
			if (ok) begin
				count_n = count_q + CW'(1);
			end
		end else begin
			ok = (count_q != '0) && found;
			if (count_q == '0) begin
				status_c = slir_pkg::ST_EMPTY;
			end else if (!found) begin
				status_c = slir_pkg::ST_NOT_FOUND;
			end else begin
				status_c = slir_pkg::ST_OK;
			end
			if (ok) begin
				count_n = count_q - CW'(1);
			end
		end
		if (count_n == '0) begin
			smallest_c = '0;
		end else begin
			smallest_c = ok ? cell_d[0] : cell_q[0];
		end
	end

	assign count_ext = {5'b0, count_n};

	always_ff @(posedge clk) begin
		if (cmd.commit && ok) begin
			for (int i = 0; i < CAPACITY; i++) begin
				cell_q[i] <= cell_d[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.commit) begin
			count_q <= count_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_q <= {1'b0, smallest_c, count_ext[4:0], status_c};
		end
	end

	assign out_data = out_q;

endmodule

@@ hw/rtl/sorted_list_insert_remove.sv @@
// Top level of the sorted list block: joins the controller and the datapath.
// Depends on slir_pkg, slir_ctrl and slir_dpath.
//
// Channel   Direction  Beat contents
// s_*       in         one request: tuser = req_type, tdata = value
// m_*       out        one result: tdata = status, entry_count, smallest
//
// The beat of a request is taken in S_IDLE, when every cell compares its entry
// with the value, and S_UPDATE then shifts the cells and writes the result
// register. The next request is taken the cycle after that.
// A result that is not taken holds S_UPDATE until the output register
// frees up; a pending result does not stop the next request being taken.
// Reset clears the entry count and the output valid flag; the cell contents
// are left as they are, since no entry above the count is ever read.
module sorted_list_insert_remove #(
	parameter int CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value (signed)
	input  logic        s_tuser,   // [0] req_type: 0 insert, 1 remove
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // [1:0] status, [6:2] entry_count, [38:7] smallest, [39] zero
);

	slir_pkg::cmd_t cmd;

	// The controller owns the handshakes and sequencing.
	slir_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	// The datapath holds the sorted cells and the result register.
	slir_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.in_req_type (s_tuser),
		.in_value    (s_tdata),
		.out_data    (m_tdata)
	);

endmodule
